/* rtl/clx_pkg.sv */
// Shared types, token codes and byte classifiers for the C source lexer.
// Used by clx_core, clx_outq and c_source_lexer_unit; depends on nothing.
`default_nettype none

package clx_pkg;

  // Width of the byte position counter; offsets and lengths leave as 24 bits
  localparam int POS_W = 24;
  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
  localparam logic [23:0] OUT_MAX = 24'hFFFFFF;
  localparam logic [23:0] LINE_MAX = 24'hFFFFFF;
  localparam logic [15:0] COL_MAX = 16'hFFFF;

  // Suffix letters allowed after a number
  localparam logic [1:0] MAX_SUFFIX = 2'd3;

  // Token codes
  localparam logic [5:0] K_WORD        = 6'd0;
  localparam logic [5:0] K_NUMBER      = 6'd1;
  localparam logic [5:0] K_STRING      = 6'd2;
  localparam logic [5:0] K_ERROR       = 6'd3;
  localparam logic [5:0] K_CHAR        = 6'd4;
  localparam logic [5:0] K_ELLIPSIS    = 6'd5;
  localparam logic [5:0] K_SHL_ASSIGN  = 6'd6;
  localparam logic [5:0] K_SHR_ASSIGN  = 6'd7;
  localparam logic [5:0] K_PAIR_BASE   = 6'd8;
  localparam logic [5:0] K_SINGLE_BASE = 6'd27;
  localparam logic [5:0] K_EOF         = 6'd51;
  localparam logic [5:0] K_HASH2       = 6'd52;
  localparam logic [5:0] K_HASH        = 6'd53;

  // Special bytes
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_BSL = 8'h5C;
  localparam logic [7:0] CH_US  = 8'h5F;

  // One emitted token
  typedef struct packed {
    logic [15:0] col;
    logic [23:0] line;
    logic [23:0] len;
    logic [23:0] off;
    logic [5:0]  kind;
  } tok_t;

  // All tokens caused by one input transaction
  typedef struct packed {
    logic [1:0]     cnt;
    tok_t [2:0]     tok;
  } bundle_t;

  function automatic logic is_word_head(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_US;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_word_body(input logic [7:0] c);
    return is_word_head(c) || is_digit(c);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic logic is_suffix(input logic [7:0] c);
    return c == "u" || c == "U" || c == "l" || c == "L" || c == "f" || c == "F";
  endfunction

  // Heads of three-byte symbols ("...", "<<=", ">>=")
  function automatic logic is_head3(input logic [7:0] c);
    return c == "." || c == "<" || c == ">";
  endfunction

  // First bytes of two-byte symbols
  function automatic logic is_pair_head(input logic [7:0] c);
    return c == "+" || c == "-" || c == "*" || c == "/" || c == "%" || c == "&" ||
           c == "|" || c == "^" || c == "=" || c == "!" || c == "<" || c == ">";
  endfunction

  // Single-byte symbol code, error code when the byte starts no token
  function automatic logic [5:0] single_kind(input logic [7:0] c);
    logic [5:0] k;
    case (c)
      "+": k = K_SINGLE_BASE + 6'd0;
      "-": k = K_SINGLE_BASE + 6'd1;
      "*": k = K_SINGLE_BASE + 6'd2;
      "/": k = K_SINGLE_BASE + 6'd3;
      "%": k = K_SINGLE_BASE + 6'd4;
      "&": k = K_SINGLE_BASE + 6'd5;
      "|": k = K_SINGLE_BASE + 6'd6;
      "^": k = K_SINGLE_BASE + 6'd7;
      "~": k = K_SINGLE_BASE + 6'd8;
      "!": k = K_SINGLE_BASE + 6'd9;
      "=": k = K_SINGLE_BASE + 6'd10;
      "<": k = K_SINGLE_BASE + 6'd11;
      ">": k = K_SINGLE_BASE + 6'd12;
      ".": k = K_SINGLE_BASE + 6'd13;
      "?": k = K_SINGLE_BASE + 6'd14;
      ":": k = K_SINGLE_BASE + 6'd15;
      ";": k = K_SINGLE_BASE + 6'd16;
      ",": k = K_SINGLE_BASE + 6'd17;
      "(": k = K_SINGLE_BASE + 6'd18;
      ")": k = K_SINGLE_BASE + 6'd19;
      "{": k = K_SINGLE_BASE + 6'd20;
      "}": k = K_SINGLE_BASE + 6'd21;
      "[": k = K_SINGLE_BASE + 6'd22;
      "]": k = K_SINGLE_BASE + 6'd23;
      default: k = K_ERROR;
    endcase
    return k;
  endfunction

  // Two-byte symbol lookup: bit 6 is the hit flag, bits 5:0 the code
  function automatic logic [6:0] pair_lookup(input logic [7:0] a, input logic [7:0] b);
    logic [6:0] r;
    case ({a, b})
      "+=": r = {1'b1, K_PAIR_BASE + 6'd0};
      "-=": r = {1'b1, K_PAIR_BASE + 6'd1};
      "*=": r = {1'b1, K_PAIR_BASE + 6'd2};
      "/=": r = {1'b1, K_PAIR_BASE + 6'd3};
      "%=": r = {1'b1, K_PAIR_BASE + 6'd4};
      "&=": r = {1'b1, K_PAIR_BASE + 6'd5};
      "|=": r = {1'b1, K_PAIR_BASE + 6'd6};
      "^=": r = {1'b1, K_PAIR_BASE + 6'd7};
      "==": r = {1'b1, K_PAIR_BASE + 6'd8};
      "!=": r = {1'b1, K_PAIR_BASE + 6'd9};
      "<=": r = {1'b1, K_PAIR_BASE + 6'd10};
      ">=": r = {1'b1, K_PAIR_BASE + 6'd11};
      "&&": r = {1'b1, K_PAIR_BASE + 6'd12};
      "||": r = {1'b1, K_PAIR_BASE + 6'd13};
      "<<": r = {1'b1, K_PAIR_BASE + 6'd14};
      ">>": r = {1'b1, K_PAIR_BASE + 6'd15};
      "++": r = {1'b1, K_PAIR_BASE + 6'd16};
      "--": r = {1'b1, K_PAIR_BASE + 6'd17};
      "->": r = {1'b1, K_PAIR_BASE + 6'd18};
      default: r = {1'b0, K_ERROR};
    endcase
    return r;
  endfunction

  // Clamp a position-width value to the 24-bit output range
  function automatic logic [23:0] clamp_out(input logic [POS_W-1:0] v);
    logic [POS_W+23:0] w;
    w = {24'd0, v};
    if (w > {{POS_W{1'b0}}, OUT_MAX}) return OUT_MAX;
    return w[23:0];
  endfunction

  function automatic tok_t mk_tok(input logic [5:0] kind, input logic [POS_W-1:0] off,
                                  input logic [POS_W-1:0] len, input logic [23:0] line,
                                  input logic [15:0] col);
    tok_t t;
    t.kind = kind;
    t.off  = clamp_out(off);
    t.len  = clamp_out(len);
    t.line = line;
    t.col  = col;
    return t;
  endfunction

  // Saturating counter steps
  function automatic logic [POS_W-1:0] pos_inc(input logic [POS_W-1:0] p, input logic [1:0] n);
    logic [POS_W:0] s;
    s = {1'b0, p} + {{(POS_W-1){1'b0}}, n};
    if (s > {1'b0, POS_MAX}) return POS_MAX;
    return s[POS_W-1:0];
  endfunction

  function automatic logic [15:0] col_inc(input logic [15:0] c, input logic [1:0] n);
    logic [16:0] s;
    s = {1'b0, c} + {15'd0, n};
    if (s > {1'b0, COL_MAX}) return COL_MAX;
    return s[15:0];
  endfunction

  function automatic logic [23:0] line_inc(input logic [23:0] l);
    if (l == LINE_MAX) return LINE_MAX;
    return l + 24'd1;
  endfunction

endpackage

`default_nettype wire

/* rtl/clx_core.sv */
// Lexer state and per-byte step logic: one source byte per transaction,
// up to three tokens out in the same cycle. Depends on clx_pkg.
`default_nettype none

module clx_core
  import clx_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step_en,
  input  wire logic [7:0] src_byte,
  input  wire logic       end_of_text,
  output bundle_t         result
);

  typedef enum logic [3:0] {
    M_IDLE, M_WORD, M_NZERO, M_NINT, M_NFRAC, M_NEXPS, M_NEXP, M_NHEX, M_NSUF,
    M_STR, M_CHR, M_LINE, M_BLOCK, M_STAR
  } mode_t;

  mode_t            mode_r, mode_nxt, em;
  logic [7:0]       la0_r, la0_nxt, la1_r, la1_nxt;
  logic [1:0]       lac_r, lac_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt, tso_r, tso_nxt;
  logic [23:0]      line_r, line_nxt, tsl_r, tsl_nxt;
  logic [15:0]      col_r, col_nxt, tsc_r, tsc_nxt;
  logic [1:0]       suf_r, suf_nxt;
  logic             cr_r, cr_nxt, esc_r, esc_nxt;

  tok_t [2:0]       tk;
  logic [1:0]       nt;
  logic             go, sg, num_tail;
  logic [7:0]       b, quote;
  logic [5:0]       lit_kind;
  logic [6:0]       pr;

  // Next state and token list for the byte at the input
  always_comb begin
    mode_nxt = mode_r; la0_nxt = la0_r; la1_nxt = la1_r; lac_nxt = lac_r;
    pos_nxt = pos_r; line_nxt = line_r; col_nxt = col_r;
    tso_nxt = tso_r; tsl_nxt = tsl_r; tsc_nxt = tsc_r;
    suf_nxt = suf_r; cr_nxt = cr_r; esc_nxt = esc_r;
    tk = '0; nt = 2'd0;
    go = 1'b0; sg = 1'b0; num_tail = 1'b0;
    b = src_byte; em = mode_r;
    quote = (mode_r == M_STR) ? "\"" : "'";
    lit_kind = (mode_r == M_STR) ? K_STRING : K_CHAR;
    pr = pair_lookup(la0_r, la1_r);

    if (end_of_text) begin
      // Flush the open token
      case (mode_r)
        M_WORD: begin
          tk[nt] = mk_tok(K_WORD, tso_r, pos_r - tso_r, tsl_r, tsc_r); nt = nt + 2'd1;
        end
        M_NZERO, M_NINT, M_NFRAC, M_NEXPS, M_NEXP, M_NHEX, M_NSUF: begin
          tk[nt] = mk_tok(K_NUMBER, tso_r, pos_r - tso_r, tsl_r, tsc_r); nt = nt + 2'd1;
        end
        M_STR, M_CHR: begin
          tk[nt] = mk_tok(K_ERROR, tso_r, pos_r - tso_r, tsl_r, tsc_r); nt = nt + 2'd1;
        end
        M_BLOCK, M_STAR: begin
          tk[nt] = mk_tok(K_ERROR, tso_r, POS_W'(2), tsl_r, tsc_r); nt = nt + 2'd1;
        end
        default: ;
      endcase
      // Flush held symbol bytes
      if (lac_r == 2'd1) begin
        tk[nt] = mk_tok((la0_r == "#") ? K_HASH : single_kind(la0_r), pos_nxt,
                        POS_W'(1), line_nxt, col_nxt);
        nt = nt + 2'd1;
        pos_nxt = pos_inc(pos_nxt, 2'd1); col_nxt = col_inc(col_nxt, 2'd1);
      end else if (lac_r == 2'd2) begin
        if (la0_r == ".") begin
          tk[nt] = mk_tok(single_kind(la0_r), pos_nxt, POS_W'(1), line_nxt, col_nxt);
          nt = nt + 2'd1;
          pos_nxt = pos_inc(pos_nxt, 2'd1); col_nxt = col_inc(col_nxt, 2'd1);
          tk[nt] = mk_tok(single_kind(la0_r), pos_nxt, POS_W'(1), line_nxt, col_nxt);
          nt = nt + 2'd1;
          pos_nxt = pos_inc(pos_nxt, 2'd1); col_nxt = col_inc(col_nxt, 2'd1);
        end else begin
          tk[nt] = mk_tok(pr[5:0], pos_nxt, POS_W'(2), line_nxt, col_nxt);
          nt = nt + 2'd1;
          pos_nxt = pos_inc(pos_nxt, 2'd2); col_nxt = col_inc(col_nxt, 2'd2);
        end
      end
      if (nt != 2'd3) begin
        tk[nt] = mk_tok(K_EOF, pos_nxt, '0, line_nxt, col_nxt);
        nt = nt + 2'd1;
      end
      // Back to the reset state for the next text
      mode_nxt = M_IDLE; lac_nxt = 2'd0;
      pos_nxt = '0; line_nxt = 24'd1; col_nxt = 16'd1;
      tso_nxt = '0; tsl_nxt = 24'd1; tsc_nxt = 16'd1;
      suf_nxt = 2'd0; cr_nxt = 1'b0; esc_nxt = 1'b0;
    end else begin
      go = 1'b1;
      // LF right after a CR belongs to the same line end
      if (cr_r) begin
        cr_nxt = 1'b0;
        if (b == CH_LF) begin
          pos_nxt = pos_inc(pos_nxt, 2'd1);
          go = 1'b0;
        end
      end

      // Byte inside an open token or comment
      if (go && mode_r != M_IDLE) begin
        go = 1'b0;
        if (mode_r == M_NZERO && !(b == "x" || b == "X")) em = M_NINT;
        if (mode_r == M_STAR && !(b == "/" || b == "*")) em = M_BLOCK;
        case (em)
          M_WORD: begin
            if (is_word_body(b)) begin
              pos_nxt = pos_inc(pos_nxt, 2'd1); col_nxt = col_inc(col_nxt, 2'd1);
            end else begin
              tk[nt] = mk_tok(K_WORD, tso_r, pos_nxt - tso_r, tsl_r, tsc_r);
              nt = nt + 2'd1;
              mode_nxt = M_IDLE; go = 1'b1;
            end
          end
          M_NZERO: begin
            pos_nxt = pos_inc(pos_nxt, 2'd1); col_nxt = col_inc(col_nxt, 2'd1);
            mode_nxt = M_NHEX;
          end
          M_NINT, M_NFRAC: begin
            if (is_digit(b)) begin
              pos_nxt = pos_inc(pos_nxt, 2'd1); col_nxt = col_inc(col_nxt, 2'd1);
              mode_nxt = em;
            end else if (b == "." && em == M_NINT) begin
              pos_nxt = pos_inc(pos_nxt, 2'd1); col_nxt = col_inc(col_nxt, 2'd1);
              mode_nxt = M_NFRAC;
            end else if (b == "e" || b == "E") begin
              pos_nxt = pos_inc(pos_nxt, 2'd1); col_nxt = col_inc(col_nxt, 2'd1);
              mode_nxt = M_NEXPS;
            end else begin
              num_tail = 1'b1;
            end
          end
          M_NEXPS: begin
            if (b == "+" || b == "-" || is_digit(b)) begin
              pos_nxt = pos_inc(pos_nxt, 2'd1); col_nxt = col_inc(col_nxt, 2'd1);
              mode_nxt = M_NEXP;
            end else begin
              num_tail = 1'b1;
            end
          end
          M_NEXP: begin
            if (is_digit(b)) begin
              pos_nxt = pos_inc(pos_nxt, 2'd1); col_nxt = col_inc(col_nxt, 2'd1);
            end else begin
              num_tail = 1'b1;
            end
          end
          M_NHEX: begin
            if (is_hex(b)) begin
              pos_nxt = pos_inc(pos_nxt, 2'd1); col_nxt = col_inc(col_nxt, 2'd1);
            end else begin
              num_tail = 1'b1;
            end
          end
          M_NSUF: num_tail = 1'b1;
          M_STR, M_CHR: begin
            if (esc_r) begin
              esc_nxt = 1'b0;
              pos_nxt = pos_inc(pos_nxt, 2'd1); col_nxt = col_inc(col_nxt, 2'd1);
            end else if (b == quote) begin
              pos_nxt = pos_inc(pos_nxt, 2'd1); col_nxt = col_inc(col_nxt, 2'd1);
              tk[nt] = mk_tok(lit_kind, tso_r, pos_nxt - tso_r, tsl_r, tsc_r);
              nt = nt + 2'd1;
              mode_nxt = M_IDLE;
            end else if (b == CH_LF || b == CH_CR) begin
              // unterminated literal; the line end is lexed as a blank
              tk[nt] = mk_tok(K_ERROR, tso_r, pos_nxt - tso_r, tsl_r, tsc_r);
              nt = nt + 2'd1;
              mode_nxt = M_IDLE; go = 1'b1;
            end else begin
              if (b == CH_BSL) esc_nxt = 1'b1;
              pos_nxt = pos_inc(pos_nxt, 2'd1); col_nxt = col_inc(col_nxt, 2'd1);
            end
          end
          M_LINE: begin
            if (b == CH_LF || b == CH_CR) begin
              mode_nxt = M_IDLE; go = 1'b1;
            end else begin
              pos_nxt = pos_inc(pos_nxt, 2'd1); col_nxt = col_inc(col_nxt, 2'd1);
            end
          end
          M_BLOCK: begin
            if (b == "*") begin
              pos_nxt = pos_inc(pos_nxt, 2'd1); col_nxt = col_inc(col_nxt, 2'd1);
              mode_nxt = M_STAR;
            end else if (b == CH_LF || b == CH_CR) begin
              pos_nxt = pos_inc(pos_nxt, 2'd1); line_nxt = line_inc(line_nxt);
              col_nxt = 16'd1;
              mode_nxt = M_BLOCK;
              if (b == CH_CR) cr_nxt = 1'b1;
            end else begin
              pos_nxt = pos_inc(pos_nxt, 2'd1); col_nxt = col_inc(col_nxt, 2'd1);
              mode_nxt = M_BLOCK;
            end
          end
          M_STAR: begin
            pos_nxt = pos_inc(pos_nxt, 2'd1); col_nxt = col_inc(col_nxt, 2'd1);
            mode_nxt = (b == "/") ? M_IDLE : M_STAR;
          end
          default: begin
            mode_nxt = M_IDLE; go = 1'b1;
          end
        endcase

        // Number tail: suffix letters, else the number ends here
        if (num_tail) begin
          if (is_suffix(b) && suf_r < MAX_SUFFIX) begin
            pos_nxt = pos_inc(pos_nxt, 2'd1); col_nxt = col_inc(col_nxt, 2'd1);
            suf_nxt = suf_r + 2'd1;
            mode_nxt = M_NSUF;
          end else begin
            tk[nt] = mk_tok(K_NUMBER, tso_r, pos_nxt - tso_r, tsl_r, tsc_r);
            nt = nt + 2'd1;
            mode_nxt = M_IDLE; go = 1'b1;
          end
        end
      end

      // Between tokens: resolve held symbol bytes with the new byte
      if (go) begin
        sg = 1'b1;
        if (lac_r == 2'd2) begin
          lac_nxt = 2'd0;
          if (la0_r == ".") begin
            if (b == ".") begin
              tk[nt] = mk_tok(K_ELLIPSIS, pos_nxt, POS_W'(3), line_nxt, col_nxt);
              nt = nt + 2'd1;
              pos_nxt = pos_inc(pos_nxt, 2'd3); col_nxt = col_inc(col_nxt, 2'd3);
              sg = 1'b0;
            end else begin
              tk[nt] = mk_tok(single_kind(la0_r), pos_nxt, POS_W'(1), line_nxt, col_nxt);
              nt = nt + 2'd1;
              pos_nxt = pos_inc(pos_nxt, 2'd1); col_nxt = col_inc(col_nxt, 2'd1);
              tk[nt] = mk_tok(single_kind(la0_r), pos_nxt, POS_W'(1), line_nxt, col_nxt);
              nt = nt + 2'd1;
              pos_nxt = pos_inc(pos_nxt, 2'd1); col_nxt = col_inc(col_nxt, 2'd1);
            end
          end else if (b == "=") begin
            tk[nt] = mk_tok((la0_r == "<") ? K_SHL_ASSIGN : K_SHR_ASSIGN, pos_nxt,
                            POS_W'(3), line_nxt, col_nxt);
            nt = nt + 2'd1;
            pos_nxt = pos_inc(pos_nxt, 2'd3); col_nxt = col_inc(col_nxt, 2'd3);
            sg = 1'b0;
          end else begin
            tk[nt] = mk_tok(pr[5:0], pos_nxt, POS_W'(2), line_nxt, col_nxt);
            nt = nt + 2'd1;
            pos_nxt = pos_inc(pos_nxt, 2'd2); col_nxt = col_inc(col_nxt, 2'd2);
          end
        end else if (lac_r == 2'd1) begin
          lac_nxt = 2'd0;
          if (la0_r == "/" && b == "/") begin
            pos_nxt = pos_inc(pos_nxt, 2'd2); col_nxt = col_inc(col_nxt, 2'd2);
            mode_nxt = M_LINE; sg = 1'b0;
          end else if (la0_r == "/" && b == "*") begin
            tso_nxt = pos_nxt; tsl_nxt = line_nxt; tsc_nxt = col_nxt;
            pos_nxt = pos_inc(pos_nxt, 2'd2); col_nxt = col_inc(col_nxt, 2'd2);
            mode_nxt = M_BLOCK; sg = 1'b0;
          end else if (la0_r == "#") begin
            if (b == "#") begin
              tk[nt] = mk_tok(K_HASH2, pos_nxt, POS_W'(2), line_nxt, col_nxt);
              nt = nt + 2'd1;
              pos_nxt = pos_inc(pos_nxt, 2'd2); col_nxt = col_inc(col_nxt, 2'd2);
              sg = 1'b0;
            end else begin
              tk[nt] = mk_tok(K_HASH, pos_nxt, POS_W'(1), line_nxt, col_nxt);
              nt = nt + 2'd1;
              pos_nxt = pos_inc(pos_nxt, 2'd1); col_nxt = col_inc(col_nxt, 2'd1);
            end
          end else if (is_head3(la0_r) && b == la0_r) begin
            // "..", "<<" or ">>": wait for a possible third byte
            la1_nxt = b; lac_nxt = 2'd2; sg = 1'b0;
          end else if (pair_lookup(la0_r, b) >= 7'h40) begin
            tk[nt] = mk_tok(pair_lookup(la0_r, b) - 7'h40 == 7'd0 ? K_PAIR_BASE :
                            pair_lookup(la0_r, b)[5:0], pos_nxt, POS_W'(2), line_nxt,
                            col_nxt);
            nt = nt + 2'd1;
            pos_nxt = pos_inc(pos_nxt, 2'd2); col_nxt = col_inc(col_nxt, 2'd2);
            sg = 1'b0;
          end else begin
            tk[nt] = mk_tok(single_kind(la0_r), pos_nxt, POS_W'(1), line_nxt, col_nxt);
            nt = nt + 2'd1;
            pos_nxt = pos_inc(pos_nxt, 2'd1); col_nxt = col_inc(col_nxt, 2'd1);
          end
        end

        // The new byte on its own
        if (sg) begin
          if (b == CH_SP || b == CH_TAB) begin
            pos_nxt = pos_inc(pos_nxt, 2'd1); col_nxt = col_inc(col_nxt, 2'd1);
          end else if (b == CH_LF || b == CH_CR) begin
            pos_nxt = pos_inc(pos_nxt, 2'd1); line_nxt = line_inc(line_nxt);
            col_nxt = 16'd1;
            if (b == CH_CR) cr_nxt = 1'b1;
          end else if (is_word_head(b)) begin
            tso_nxt = pos_nxt; tsl_nxt = line_nxt; tsc_nxt = col_nxt;
            pos_nxt = pos_inc(pos_nxt, 2'd1); col_nxt = col_inc(col_nxt, 2'd1);
            mode_nxt = M_WORD;
          end else if (is_digit(b)) begin
            tso_nxt = pos_nxt; tsl_nxt = line_nxt; tsc_nxt = col_nxt;
            pos_nxt = pos_inc(pos_nxt, 2'd1); col_nxt = col_inc(col_nxt, 2'd1);
            suf_nxt = 2'd0;
            mode_nxt = (b == "0") ? M_NZERO : M_NINT;
          end else if (b == "\"" || b == "'") begin
            tso_nxt = pos_nxt; tsl_nxt = line_nxt; tsc_nxt = col_nxt;
            pos_nxt = pos_inc(pos_nxt, 2'd1); col_nxt = col_inc(col_nxt, 2'd1);
            esc_nxt = 1'b0;
            mode_nxt = (b == "\"") ? M_STR : M_CHR;
          end else if (b == "#" || is_head3(b) || is_pair_head(b)) begin
            la0_nxt = b; lac_nxt = 2'd1;
          end else if (nt != 2'd3) begin
            tk[nt] = mk_tok(single_kind(b), pos_nxt, POS_W'(1), line_nxt, col_nxt);
            nt = nt + 2'd1;
            pos_nxt = pos_inc(pos_nxt, 2'd1); col_nxt = col_inc(col_nxt, 2'd1);
          end
        end
      end
    end

    result.tok = tk;
    result.cnt = nt;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      lac_r  <= 2'd0;
      pos_r  <= '0;
      line_r <= 24'd1;
      col_r  <= 16'd1;
      tso_r  <= '0;
      tsl_r  <= 24'd1;
      tsc_r  <= 16'd1;
      suf_r  <= 2'd0;
      cr_r   <= 1'b0;
      esc_r  <= 1'b0;
    end else if (step_en) begin
      mode_r <= mode_nxt;
      lac_r  <= lac_nxt;
      pos_r  <= pos_nxt;
      line_r <= line_nxt;
      col_r  <= col_nxt;
      tso_r  <= tso_nxt;
      tsl_r  <= tsl_nxt;
      tsc_r  <= tsc_nxt;
      suf_r  <= suf_nxt;
      cr_r   <= cr_nxt;
      esc_r  <= esc_nxt;
    end
  end

  // Held symbol bytes, qualified by lac_r
  always_ff @(posedge clk) begin
    if (step_en) begin
      la0_r <= la0_nxt;
      la1_r <= la1_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/clx_outq.sv */
// Result queue: stores the token group of each input transaction and hands
// the tokens out one per output transaction. Depends on clx_pkg.
`default_nettype none

module clx_outq
  import clx_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push_valid,
  input  bundle_t      push_data,
  output logic         push_ready,
  output logic         out_valid,
  input  wire logic    out_ready,
  output tok_t         out_tok,
  output logic         out_last
);

  localparam int QDEPTH = 4;
  localparam int QAW = $clog2(QDEPTH);

  bundle_t        q_r [QDEPTH];
  logic [QAW-1:0] wp_r, rp_r;
  logic [QAW:0]   cnt_r, cnt_nxt;
  logic [1:0]     sub_r;
  bundle_t        head;
  logic           push, pop, step;

  assign push_ready = (cnt_r != (QAW+1)'(QDEPTH));
  assign push       = push_valid && push_ready;
  assign out_valid  = (cnt_r != '0);
  assign head       = q_r[rp_r];
  assign out_last   = (sub_r == head.cnt - 2'd1);
  assign step       = out_valid && out_ready;
  assign pop        = step && out_last;

  // Token select within the head group
  always_comb begin
    case (sub_r)
      2'd0:    out_tok = head.tok[0];
      2'd1:    out_tok = head.tok[1];
      default: out_tok = head.tok[2];
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (!push && pop) cnt_nxt = cnt_r - 1'b1;
  end

  // Pointers and token index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
      sub_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) begin
        rp_r  <= rp_r + 1'b1;
        sub_r <= 2'd0;
      end else if (step) begin
        sub_r <= sub_r + 2'd1;
      end
    end
  end

  // Group storage
  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= push_data;
  end

endmodule

`default_nettype wire

/* rtl/c_source_lexer_unit.sv */
// Top level of the streaming C source lexer: byte stream in, token stream out.
// Depends on clx_pkg, clx_core and clx_outq.
//
// Usage:
//   Input channel in_*: one source byte per transaction in in_tdata; in_tlast
//   marks the end item (byte ignored), which flushes the open token and held
//   symbol bytes, emits EOF and returns the lexer to offset 0, line 1, col 1.
//   Output channel out_*: one token per transaction; out_tlast is set on the
//   last token caused by an input transaction. Items that cause no token
//   produce no output transaction.
//   Throughput: one input transaction per cycle while in_tready is high.
//   Each byte is lexed in the cycle it is accepted by single-pass logic that
//   yields up to three tokens; the output side then drains one token per
//   cycle while out_tready is high, so sustained rate is set by the token
//   count of the stream. Each byte's tokens are registered in the result
//   queue, which holds four token groups; in_tready falls only when it is
//   full, so a stalled receiver backs up into the input after four groups.
//   Reset (rst_n low, synchronous) empties the queue and clears lexer state.
`default_nettype none

module c_source_lexer_unit
  import clx_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] src_byte
  input  wire logic        in_tlast,   // end_of_text
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [95:0]      out_tdata,  // [5:0] token_kind, [29:6] start_offset,
                                       // [53:30] token_length, [77:54] start_line,
                                       // [93:78] start_column, [95:94] zero
  output logic             out_tlast   // last_of_run
);

  bundle_t grp;
  tok_t    tok;
  logic    accept;

  assign accept = in_tvalid && in_tready;

  clx_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (accept),
    .src_byte    (in_tdata),
    .end_of_text (in_tlast),
    .result      (grp)
  );

  clx_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (accept && grp.cnt != 2'd0),
    .push_data  (grp),
    .push_ready (in_tready),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_tok    (tok),
    .out_last   (out_tlast)
  );

  // Pack the token fields, lowest field first
  assign out_tdata = {2'b00, tok.col, tok.line, tok.len, tok.off, tok.kind};

endmodule

`default_nettype wire
